FILE: src/sctr_pkg.sv
// Package: shared types, codes and constants for the sparse column tie rank block.
package sctr_pkg;

	localparam int MAX_NONZEROS_DEF = 32;
	localparam int ROWS_W = 20;
	localparam int CMD_DEPTH = 4;

	localparam logic [1:0] KIND_RANK  = 2'd0;
	localparam logic [1:0] KIND_GROUP = 2'd1;
	localparam logic [1:0] KIND_ZERO  = 2'd2;

	typedef struct packed {
		logic [31:0] value;
		logic        last_of_column;
		logic        column_empty;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  position;
		logic [20:0] rank_doubled;
		logic [19:0] group_count;
		logic        overflow;
		logic        last;
	} res_item_t;

	// classified request as handed from front to back
	typedef struct packed {
		logic        store;
		logic        close;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_chan_t;

endpackage

FILE: src/sparse_column_tie_rank_core.sv
// Top level: average-rank-with-ties engine for one sparse column at a time.
//
// Push the nonzero values of a column, the final one flagged last_of_column
// (or push a column_empty request to close it). The block returns one doubled
// mean rank per stored entry in arrival order (offset by twice the implicit
// zero count, num_rows minus stored entries, clamped at 0), then one size per
// tie group of two or more in ascending value order, then the zero count,
// flagged last. Entries beyond MAX_NONZEROS are dropped and every result of
// that column carries overflow. Plain loads go through a four-deep request
// queue and are stored at one per cycle while the sequencer is idle.
// Closing a column of n entries runs the ranking sequencer over the
// single-port value memory: each rank takes a fetch, a latch, one full
// scan and an emit, and each distinct value, plus one final pass that finds
// none left, takes another full scan to find the tie groups, with an emit per
// group of two or more; no new request is taken from the queue meanwhile. A
// stalled result holds the sequencer in its emit step. The user must write
// num_rows via cfg_we / cfg_wdata while the block is idle; it is not enforced.
module sparse_column_tie_rank_core
	import sctr_pkg::*;
#(
	parameter int MAX_NONZEROS = MAX_NONZEROS_DEF
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  req_item_t         req,
	output logic              empty,
	input  logic              pop,
	output res_item_t         res,
	input  logic              cfg_we,
	input  logic [ROWS_W-1:0] cfg_wdata
);

	cmd_chan_t         cmd_chan;
	logic              cmd_pop;
	logic [ROWS_W-1:0] num_rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= '0;
		end else if (cfg_we) begin
			num_rows_q <= cfg_wdata;
		end
	end

	sctr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.req     (req),
		.cmd_out (cmd_chan),
		.cmd_pop (cmd_pop)
	);

	sctr_back #(
		.MAX_NONZEROS (MAX_NONZEROS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_in   (cmd_chan),
		.cmd_pop  (cmd_pop),
		.num_rows (num_rows_q),
		.empty    (empty),
		.pop      (pop),
		.res      (res)
	);

endmodule

FILE: src/sctr_front.sv
// Front: takes requests, classifies them into store/close commands, queues them.
module sctr_front
	import sctr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  req_item_t req,
	output cmd_chan_t cmd_out,
	input  logic      cmd_pop
);

	localparam int PW = $clog2(CMD_DEPTH);

	cmd_t           q_q [CMD_DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [PW:0]    count_q;
	logic           do_push, do_pop;
	cmd_t           cmd_new;

	assign full    = (count_q == (PW+1)'(CMD_DEPTH));
	assign do_push = push && !full;
	assign do_pop  = cmd_pop && (count_q != '0);

	always_comb begin
		cmd_new.store = !req.column_empty;
		cmd_new.close = req.column_empty || req.last_of_column;
		cmd_new.value = req.value;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end

	assign cmd_out.valid = (count_q != '0);
	assign cmd_out.cmd   = q_q[rd_ptr_q];

endmodule

FILE: src/sctr_back.sv
// Back: value memory and the ranking sequencer with its result register.
module sctr_back
	import sctr_pkg::*;
#(
	parameter int MAX_NONZEROS = MAX_NONZEROS_DEF
)(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_chan_t         cmd_in,
	output logic              cmd_pop,
	input  logic [ROWS_W-1:0] num_rows,
	output logic              empty,
	input  logic              pop,
	output res_item_t         res
);

	localparam int AW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
	localparam int CW = $clog2(MAX_NONZEROS + 1);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_RFETCH = 7'b0000010,
		S_RCUR   = 7'b0000100,
		S_RSCAN  = 7'b0001000,
		S_REMIT  = 7'b0010000,
		S_GSCAN  = 7'b0100000,
		S_EMIT   = 7'b1000000
	} state_t;

	logic [31:0]       mem [MAX_NONZEROS];
	logic [31:0]       rdata_q;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;

	state_t            state_q;
	logic [CW-1:0]     cnt_q, n_q, i_q, j_q, less_q, eq_q, gcnt_q;
	logic              ovf_q, col_ovf_q, pv_q;
	logic [ROWS_W-1:0] zeros_q;
	logic [31:0]       cur_q, best_q, prev_q;
	logic              have_prev_q, found_q, zero_pend_q;
	logic              out_v_q;
	res_item_t         out_q;
	logic              slot_free;
	logic              out_load;
	logic              can_store;
	logic [CW-1:0]     n_next;
	logic [21:0]       rank_val;
	logic              cand;

	assign slot_free = !out_v_q || pop;
	assign out_load  = slot_free && ((state_q == S_REMIT) || (state_q == S_EMIT));
	assign empty     = !out_v_q;
	assign res       = out_q;
	assign cmd_pop   = (state_q == S_IDLE) && cmd_in.valid;

	assign can_store = cnt_q != CW'(MAX_NONZEROS);
	assign wr_en     = cmd_pop && cmd_in.cmd.store && can_store;
	assign n_next    = cnt_q + CW'(wr_en);

	assign rd_en   = (state_q == S_RFETCH) ||
	                 (((state_q == S_RSCAN) || (state_q == S_GSCAN)) && (j_q != n_q));
	assign rd_addr = (state_q == S_RFETCH) ? i_q[AW-1:0] : j_q[AW-1:0];

	assign rank_val = 22'({less_q, 1'b0}) + 22'(eq_q) + 22'd1 + 22'({zeros_q, 1'b0});
	assign cand     = !have_prev_q || (rdata_q > prev_q);

	always_ff @(posedge clk) begin
		if (wr_en) mem[cnt_q[AW-1:0]] <= cmd_in.cmd.value;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_v_q     <= 1'b0;
			out_q       <= '0;
			pv_q        <= 1'b0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			less_q      <= '0;
			eq_q        <= '0;
			gcnt_q      <= '0;
			cur_q       <= '0;
			best_q      <= '0;
			prev_q      <= '0;
			col_ovf_q   <= 1'b0;
			zeros_q     <= '0;
			have_prev_q <= 1'b0;
			found_q     <= 1'b0;
			zero_pend_q <= 1'b0;
		end else begin
			if (pop && out_v_q && !out_load) out_v_q <= 1'b0;
			pv_q <= rd_en && (state_q != S_RFETCH);
			if (rd_en && (state_q != S_RFETCH)) j_q <= j_q + 1'b1;

			unique case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						if (cmd_in.cmd.close) begin
							n_q       <= n_next;
							col_ovf_q <= ovf_q || (cmd_in.cmd.store && !can_store);
							zeros_q   <= (num_rows > ROWS_W'(n_next)) ?
							             num_rows - ROWS_W'(n_next) : '0;
							cnt_q     <= '0;
							ovf_q     <= 1'b0;
							i_q       <= '0;
							if (n_next == '0) begin
								zero_pend_q <= 1'b1;
								state_q     <= S_EMIT;
							end else begin
								state_q <= S_RFETCH;
							end
						end else begin
							if (wr_en) cnt_q <= n_next;
							if (cmd_in.cmd.store && !can_store) ovf_q <= 1'b1;
						end
					end
				end
				S_RFETCH: state_q <= S_RCUR;
				S_RCUR: begin
					cur_q   <= rdata_q;
					j_q     <= '0;
					less_q  <= '0;
					eq_q    <= '0;
					state_q <= S_RSCAN;
				end
				S_RSCAN: begin
					if (pv_q) begin
						if (rdata_q < cur_q) less_q <= less_q + 1'b1;
						else if (rdata_q == cur_q) eq_q <= eq_q + 1'b1;
					end
					if ((j_q == n_q) && !pv_q) state_q <= S_REMIT;
				end
				S_REMIT: begin
					if (slot_free) begin
						out_v_q            <= 1'b1;
						out_q.kind         <= KIND_RANK;
						out_q.position     <= 5'(i_q);
						out_q.rank_doubled <= rank_val[20:0];
						out_q.group_count  <= '0;
						out_q.overflow     <= col_ovf_q;
						out_q.last         <= 1'b0;
						i_q                <= i_q + 1'b1;
						if (i_q + 1'b1 == n_q) begin
							have_prev_q <= 1'b0;
							found_q     <= 1'b0;
							j_q         <= '0;
							state_q     <= S_GSCAN;
						end else begin
							state_q <= S_RFETCH;
						end
					end
				end
				S_GSCAN: begin
					// find the smallest value above the previous group, with its count
					if (pv_q && cand) begin
						if (!found_q || (rdata_q < best_q)) begin
							best_q  <= rdata_q;
							gcnt_q  <= CW'(1);
							found_q <= 1'b1;
						end else if (rdata_q == best_q) begin
							gcnt_q <= gcnt_q + 1'b1;
						end
					end
					if ((j_q == n_q) && !pv_q) begin
						if (!found_q) begin
							zero_pend_q <= 1'b1;
							state_q     <= S_EMIT;
						end else begin
							prev_q      <= best_q;
							have_prev_q <= 1'b1;
							found_q     <= 1'b0;
							if (gcnt_q > CW'(1)) begin
								zero_pend_q <= 1'b0;
								state_q     <= S_EMIT;
							end else begin
								j_q <= '0;
							end
						end
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						out_v_q            <= 1'b1;
						out_q.position     <= '0;
						out_q.rank_doubled <= '0;
						out_q.overflow     <= col_ovf_q;
						if (zero_pend_q) begin
							out_q.kind        <= KIND_ZERO;
							out_q.group_count <= zeros_q;
							out_q.last        <= 1'b1;
							state_q           <= S_IDLE;
						end else begin
							out_q.kind        <= KIND_GROUP;
							out_q.group_count <= ROWS_W'(gcnt_q);
							out_q.last        <= 1'b0;
							j_q               <= '0;
							state_q           <= S_GSCAN;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: test/tb_top.sv
// Testbench for sparse_column_tie_rank_core: random columns checked against a tie-rank predictor.
`timescale 1ns / 1ps

module tb_top;
	import sctr_pkg::*;

	localparam int CAP = MAX_NONZEROS_DEF;
	localparam int STALL_LIMIT = 200000;

	// Scoreboard: predicts the ranking of each closed column and checks results.
	class rank_board;
		logic [19:0] num_rows;
		logic [31:0] col_vals[$];
		bit col_ovf;
		res_item_t pending[$];
		int errors;

		function new();
			num_rows = '0;
			col_ovf = 0;
			errors = 0;
		endfunction

		function void add_result(logic [1:0] kind, int pos, int rank2, int cnt, bit lst);
			res_item_t r;
			r.kind = kind;
			r.position = pos[4:0];
			r.rank_doubled = rank2[20:0];
			r.group_count = cnt[19:0];
			r.overflow = col_ovf;
			r.last = lst;
			pending = {pending, r};
		endfunction

		// note one accepted request
		function void note_request(req_item_t q);
			int n, zeros, less, eq, j;
			logic [31:0] srt[$];
			if (!q.column_empty) begin
				if (col_vals.size() < CAP) col_vals = {col_vals, q.value};
				else col_ovf = 1;
				if (!q.last_of_column) return;
			end
			n = col_vals.size();
			zeros = (num_rows > n) ? num_rows - n : 0;
			for (int i = 0; i < n; i++) begin
				less = 0;
				eq = 0;
				foreach (col_vals[k]) begin
					if (col_vals[k] < col_vals[i]) less++;
					else if (col_vals[k] == col_vals[i]) eq++;
				end
				add_result(KIND_RANK, i, 2*less + eq + 1 + 2*zeros, 0, 0);
			end
			srt = col_vals;
			srt.sort();
			for (int i = 0; i < n; i = j) begin
				j = i + 1;
				while (j < n && srt[j] == srt[i]) j++;
				if (j - i > 1) add_result(KIND_GROUP, 0, 0, j - i, 0);
			end
			add_result(KIND_ZERO, 0, 0, zeros, 1);
			col_vals.delete();
			col_ovf = 0;
		endfunction

		function void check_result(res_item_t got);
			res_item_t want;
			if (pending.size() == 0) begin
				$display("%0t unexpected result: expected none, got %p", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.kind !== want.kind || got.position !== want.position ||
			    got.rank_doubled !== want.rank_doubled ||
			    got.group_count !== want.group_count ||
			    got.overflow !== want.overflow || got.last !== want.last) begin
				$display("%0t mismatch: expected %p, got %p", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	req_item_t req = '0;
	logic empty;
	logic pop = 0;
	res_item_t res;
	logic cfg_we = 0;
	logic [ROWS_W-1:0] cfg_wdata = '0;

	rank_board board = new();
	int idle_cycles = 0;

	always #1 clk = ~clk;

	sparse_column_tie_rank_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .res(res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// one request, after a random gap; waits until it is taken
	// push stays high when the next request follows with no gap
	task automatic send(logic [31:0] v, bit lst, bit emp);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		push <= 1;
		req <= '{value: v, last_of_column: lst, column_empty: emp};
		do @(posedge clk); while (full);
		board.note_request(req);
	endtask

	function automatic logic [31:0] pick_value(int pool);
		case ($urandom_range(0, 4))
			0: return 32'hFFFF_FFFF;
			1: return 32'd1;
			2: return $urandom();
			default: return $urandom_range(0, pool);
		endcase
	endfunction

	// a column of n loads; the last one closes it, or a column_empty closer follows
	task automatic send_column(int n, int pool);
		bit via_empty;
		via_empty = ($urandom_range(0, 5) == 0);
		for (int i = 0; i < n; i++)
			send(pick_value(pool), !via_empty && i == n - 1, 0);
		if (via_empty || n == 0) send($urandom(), $urandom_range(0, 1), 1);
	endtask

	// wait for every expected result, then let the sequencer settle
	task automatic drain();
		push <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_rows(logic [19:0] rows);
		cfg_we <= 1;
		cfg_wdata <= rows;
		@(posedge clk);
		cfg_we <= 0;
		board.num_rows = rows;
	endtask

	// result side: random stall per result
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			if (gap > 0) begin
				pop <= 0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1;
			do @(posedge clk); while (empty);
			board.check_result(res);
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int items;
		logic [19:0] rows_set[4];
		rows_set = '{20'd0, 20'hFFFFF, 20'd10, 20'd40};
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty column at reset rows, extremes, ties, overflow
		send(32'h0, 0, 1);
		drain();
		write_rows(20'hFFFFF);
		send(32'hFFFF_FFFF, 0, 0);
		send(32'h0, 0, 0);
		send(32'hFFFF_FFFF, 0, 0);
		send(32'h5555_AAAA, 1, 0);
		send(32'hAAAA_5555, 1, 1);  // both flags: empty wins
		send(32'h7, 0, 0);
		send(32'h7, 0, 0);
		send(32'h1234, 0, 1);       // closes a loaded column
		drain();
		write_rows(20'd5);
		for (int i = 0; i < CAP + 2; i++) send(i % 3, i == CAP + 1, 0);
		drain();
		write_rows(20'd0);
		send(32'd9, 1, 0);

		// random columns across several row settings
		items = 0;
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			write_rows(ph == 3 ? 20'($urandom()) : rows_set[ph]);
			while (items < (ph + 1) * 75) begin
				int n;
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(CAP - 2, CAP + 3)
				                                : $urandom_range(0, 8);
				send_column(n, ($urandom_range(0, 1)) ? 3 : 1000);
				items += (n == 0) ? 1 : n;
			end
		end
		drain();
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
